// ===== hdl/random_permutation_shuffle_unit_macros.svh =====
// Assertion helpers for the shuffle unit, clocked on clock, quiet in reset.
`ifndef RANDOM_PERMUTATION_SHUFFLE_UNIT_MACROS_SVH
`define RANDOM_PERMUTATION_SHUFFLE_UNIT_MACROS_SVH

// same-cycle implication
`define RPS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rps_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   // fixed field widths
   localparam int LEN_W   = 11;
   localparam int FRAC_W  = 31;
   localparam int VALUE_W = 11;
   localparam int POS_W   = 10;

   localparam int PROD_W  = CNT_W + FRAC_W;

   // per-permutation tag held with each stored entry; tag 0 means cleared
   localparam int EPOCH_W = 8;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

   typedef enum logic [2:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_WRAP_CLEAR,
      ST_CALC,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic accept;      // latch request, compute product
      logic clear_step;  // write one cleared tag
      logic calc;        // form partner index, read both entries
      logic finish;      // write partner entry, load result
   } cmd_type;

   typedef struct packed {
      logic start_new;   // next request begins a permutation
      logic epoch_full;  // tag space used up
      logic clear_last;  // clearing pass at final entry
      logic out_free;    // result register can take a value
   } status_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [CNT_W-1:0]   value;
   } entry_type;

endpackage

`default_nettype wire

// ===== hdl/rps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rps_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  rps_pkg::status_type     status,
   output rps_pkg::cmd_type        cmd
);

   rps_pkg::state_type state_ff;
   rps_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rps_pkg::ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rps_pkg::ST_INIT_CLEAR: begin
            if (status.clear_last) state_in = rps_pkg::ST_IDLE;
         end
         rps_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.start_new && status.epoch_full) begin
                  state_in = rps_pkg::ST_WRAP_CLEAR;
               end else begin
                  state_in = rps_pkg::ST_CALC;
               end
            end
         end
         rps_pkg::ST_WRAP_CLEAR: begin
            if (status.clear_last) state_in = rps_pkg::ST_CALC;
         end
         rps_pkg::ST_CALC: begin
            state_in = rps_pkg::ST_WRITE;
         end
         rps_pkg::ST_WRITE: begin
            if (status.out_free) state_in = rps_pkg::ST_IDLE;
         end
         default: begin
            state_in = rps_pkg::ST_INIT_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rps_pkg::ST_INIT_CLEAR,
         rps_pkg::ST_WRAP_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         rps_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         rps_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
         end
         rps_pkg::ST_WRITE: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/rps_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rps_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [rps_pkg::LEN_W-1:0]    csr_wr_data,
   input  wire logic [rps_pkg::FRAC_W-1:0]   req_random_fraction,
   input  rps_pkg::cmd_type                  cmd,
   output rps_pkg::status_type               status,
   input  wire logic                         rsp_ready,
   output logic                              rsp_valid,
   output logic [rps_pkg::VALUE_W-1:0]       rsp_element_value,
   output logic [rps_pkg::POS_W-1:0]         rsp_position,
   output logic                              rsp_last_element
);

   localparam int ADDR_W  = rps_pkg::ADDR_W;
   localparam int CNT_W   = rps_pkg::CNT_W;
   localparam int EPOCH_W = rps_pkg::EPOCH_W;

   // value store with per-entry tag
   rps_pkg::entry_type mem_ff [rps_pkg::MAX_ELEMENTS];
   rps_pkg::entry_type rd_i_ff;
   rps_pkg::entry_type rd_j_ff;

   logic [rps_pkg::LEN_W-1:0]  len_ff;
   logic [ADDR_W-1:0]          position_ff;
   logic [ADDR_W-1:0]          position_in;
   logic [EPOCH_W-1:0]         epoch_ff;
   logic [ADDR_W-1:0]          clr_addr_ff;

   logic [ADDR_W-1:0]          i_ff;
   logic [CNT_W-1:0]           n_ff;
   logic [rps_pkg::PROD_W-1:0] prod_ff;
   logic [ADDR_W-1:0]          j_ff;

   logic                       rsp_valid_ff;
   logic [rps_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [rps_pkg::POS_W-1:0]  rsp_pos_ff;
   logic                       rsp_last_ff;

   logic [CNT_W-1:0]           n;
   logic [CNT_W-1:0]           cur_i;
   logic [CNT_W:0]             j_sum;
   logic [ADDR_W-1:0]          j_idx;
   logic [CNT_W-1:0]           vi;
   logic [CNT_W-1:0]           vj;
   logic                       last;
   logic                       clear_last;

   // clamp length to 1..MAX_ELEMENTS
   always_comb begin
      if (len_ff == '0) begin
         n = CNT_W'(1);
      end else if (32'(len_ff) > rps_pkg::MAX_ELEMENTS) begin
         n = CNT_W'(rps_pkg::MAX_ELEMENTS);
      end else begin
         n = CNT_W'(len_ff);
      end
   end

   // a shortened length restarts the permutation
   assign cur_i = (CNT_W'(position_ff) >= n) ? '0 : CNT_W'(position_ff);

   assign clear_last = (clr_addr_ff == ADDR_W'(rps_pkg::MAX_ELEMENTS - 1));

   // partner index: i + floor((n - i) * r / 2^31), held below n
   assign j_sum = (CNT_W + 1)'(i_ff) + (CNT_W + 1)'(prod_ff[rps_pkg::FRAC_W +: CNT_W]);
   always_comb begin
      if (j_sum >= (CNT_W + 1)'(n_ff)) begin
         j_idx = ADDR_W'(n_ff - CNT_W'(1));
      end else begin
         j_idx = ADDR_W'(j_sum);
      end
   end

   // entries without the current tag still hold their identity value
   assign vi = (rd_i_ff.tag == epoch_ff) ? rd_i_ff.value : CNT_W'(i_ff) + CNT_W'(1);
   assign vj = (rd_j_ff.tag == epoch_ff) ? rd_j_ff.value : CNT_W'(j_ff) + CNT_W'(1);

   assign last = (CNT_W'(i_ff) == n_ff - CNT_W'(1));

   always_comb begin
      position_in = position_ff;
      if (cmd.finish) begin
         position_in = last ? '0 : i_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= rps_pkg::LEN_RESET;
         position_ff  <= '0;
         epoch_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) len_ff <= csr_wr_data;
         position_ff <= position_in;
         if (cmd.clear_step) begin
            clr_addr_ff <= clear_last ? '0 : clr_addr_ff + ADDR_W'(1);
            if (clear_last) epoch_ff <= EPOCH_W'(1);
         end else if (cmd.accept && (cur_i == '0) && (epoch_ff != '1)) begin
            epoch_ff <= epoch_ff + EPOCH_W'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         i_ff    <= ADDR_W'(cur_i);
         n_ff    <= n;
         prod_ff <= rps_pkg::PROD_W'(n - cur_i) * rps_pkg::PROD_W'(req_random_fraction);
      end
      if (cmd.calc) begin
         j_ff <= j_idx;
      end
      if (cmd.finish) begin
         rsp_value_ff <= rps_pkg::VALUE_W'(vj);
         rsp_pos_ff   <= rps_pkg::POS_W'(i_ff);
         rsp_last_ff  <= last;
      end
   end

   // entry i is final once emitted and is never read again in this permutation,
   // so only the partner entry is written back
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem_ff[clr_addr_ff] <= '{tag: '0, value: '0};
      end else if (cmd.finish) begin
         mem_ff[j_ff] <= '{tag: epoch_ff, value: vi};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         rd_i_ff <= mem_ff[i_ff];
         rd_j_ff <= mem_ff[j_idx];
      end
   end

   assign status.start_new  = (cur_i == '0);
   assign status.epoch_full = (epoch_ff == '1);
   assign status.clear_last = clear_last;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_value = rsp_value_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_last_element  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/random_permutation_shuffle_unit.sv =====
// Fisher-Yates shuffle unit: builds random permutations of 1..N, one element
// per request.
// req_*: valid/ready request channel carrying a 31-bit random fraction.
// rsp_*: valid/ready result channel with the final value at one position,
//   the position and a flag marking the last position of the permutation.
// csr_wr_en/csr_wr_data: write of the permutation length N (reset 1024),
//   done while the unit is idle; a rule for the user, not enforced by the unit.
// Each request goes through accept with the (N-i)*r product, then partner index
// and two-port store read, then partner write-back and result load. The result
// is registered in the output register, and the next request is taken only after
// the previous one is finished, set by the store read-then-write sequence.
// Stored entries carry an 8-bit permutation tag. After reset a clearing pass of
// 1024 entries runs before the first request is taken; the same pass runs again
// at the start of every 255th permutation. Length writes are taken throughout.
// If the receiver stalls, the result waits in the output register and the unit
// holds its write-back until that register frees up.
`timescale 1ns / 1ps
`default_nettype none

`include "random_permutation_shuffle_unit_macros.svh"

module random_permutation_shuffle_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [rps_pkg::LEN_W-1:0]    csr_wr_data,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [rps_pkg::FRAC_W-1:0]   req_random_fraction,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [rps_pkg::VALUE_W-1:0]       rsp_element_value,
   output logic [rps_pkg::POS_W-1:0]         rsp_position,
   output logic                              rsp_last_element
);

   rps_pkg::cmd_type    cmd;
   rps_pkg::status_type status;

   rps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rps_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_random_fraction (req_random_fraction),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_element_value   (rsp_element_value),
      .rsp_position        (rsp_position),
      .rsp_last_element    (rsp_last_element)
   );

   // one request in flight at a time
   `RPS_ASSERT_NEXT(a_single_request, req_valid && req_ready, !req_ready, "request overlap")

   // a finished request shows up on the result channel
   `RPS_ASSERT_NEXT(a_result_loaded, cmd.finish, rsp_valid, "result not loaded")

   // no request taken while the store is being cleared
   `RPS_ASSERT_IMPL(a_no_accept_in_clear, cmd.clear_step, !req_ready, "accept during clear")

endmodule

`default_nettype wire

// ===== test/random_permutation_shuffle_unit_tb.sv =====
`timescale 1ns / 1ps

module random_permutation_shuffle_unit_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [rps_pkg::FRAC_W-1:0] FRAC_MAX = {rps_pkg::FRAC_W{1'b1}};

   typedef struct {
      logic [rps_pkg::VALUE_W-1:0] element_value;
      logic [rps_pkg::POS_W-1:0]   position;
      logic                        last_element;
   } element_result_type;

   // Tracks the shuffle state and the final elements still owed by the block.
   class permutation_tracker;
      int unsigned                 errors;
      logic [rps_pkg::LEN_W-1:0]   length_reg;
      bit [rps_pkg::VALUE_W-1:0]   entry_value [rps_pkg::MAX_ELEMENTS];
      bit                          entry_written [rps_pkg::MAX_ELEMENTS];
      int unsigned                 next_pos;
      element_result_type          expected_elements [$];

      function new();
         errors = 0;
         length_reg = rps_pkg::LEN_RESET;
         next_pos = 0;
         foreach (entry_written[k]) entry_written[k] = 1'b0;
      endfunction

      function void set_length(logic [rps_pkg::LEN_W-1:0] n);
         length_reg = n;
      endfunction

      function int unsigned pending();
         return expected_elements.size();
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
         errors++;
      endtask

      // One accepted request: pick the partner, swap, emit entry i.
      function void take_fraction(logic [rps_pkg::FRAC_W-1:0] frac);
         int unsigned        n;
         int unsigned        i;
         int unsigned        j;
         int unsigned        vi;
         int unsigned        vj;
         longint unsigned    span;
         element_result_type res;
         n = length_reg;
         if (n < 1) n = 1;
         if (n > rps_pkg::MAX_ELEMENTS) n = rps_pkg::MAX_ELEMENTS;
         if (next_pos >= n) next_pos = 0;
         if (next_pos == 0) begin
            foreach (entry_written[k]) entry_written[k] = 1'b0;
         end
         i = next_pos;
         span = 64'(n - i) * 64'(frac);
         j = i + 32'(span >> rps_pkg::FRAC_W);
         if (j >= n) j = n - 1;
         vi = entry_written[i] ? 32'(entry_value[i]) : i + 1;
         vj = entry_written[j] ? 32'(entry_value[j]) : j + 1;
         entry_value[j] = rps_pkg::VALUE_W'(vi);
         entry_written[j] = 1'b1;
         entry_value[i] = rps_pkg::VALUE_W'(vj);
         entry_written[i] = 1'b1;
         res.element_value = rps_pkg::VALUE_W'(vj);
         res.position = rps_pkg::POS_W'(i);
         res.last_element = (i == n - 1);
         expected_elements.push_back(res);
         next_pos = res.last_element ? 0 : i + 1;
      endfunction

      task check_element(logic [rps_pkg::VALUE_W-1:0] v, logic [rps_pkg::POS_W-1:0] p,
                         logic l);
         element_result_type want;
         if (expected_elements.size() == 0) begin
            report_mismatch("result with nothing pending, position", int'(p), -1);
            return;
         end
         want = expected_elements.pop_front();
         if (v !== want.element_value)
            report_mismatch($sformatf("element_value at position %0d", want.position),
                            int'(v), int'(want.element_value));
         if (p !== want.position)
            report_mismatch("position", int'(p), int'(want.position));
         if (l !== want.last_element)
            report_mismatch($sformatf("last_element at position %0d", want.position),
                            int'(l), int'(want.last_element));
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_wr_en;
   logic [rps_pkg::LEN_W-1:0]     csr_wr_data;
   logic                          req_valid;
   logic                          req_ready;
   logic [rps_pkg::FRAC_W-1:0]    req_random_fraction;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [rps_pkg::VALUE_W-1:0]   rsp_element_value;
   logic [rps_pkg::POS_W-1:0]     rsp_position;
   logic                          rsp_last_element;

   int unsigned          cycle_count = 0;
   int unsigned          src_idle_pct = 0;
   int unsigned          sink_idle_pct = 0;
   permutation_tracker   tracker = new();

   random_permutation_shuffle_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_element_value   (rsp_element_value),
      .rsp_position        (rsp_position),
      .rsp_last_element    (rsp_last_element)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: check on handshake, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_element(rsp_element_value, rsp_position, rsp_last_element);
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
   end

   task automatic send_fraction(input logic [rps_pkg::FRAC_W-1:0] frac);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_random_fraction <= frac;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_fraction(frac);
   endtask

   // block idle: no request in flight, all results back, write-back settled
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [rps_pkg::LEN_W-1:0] n);
      csr_wr_en <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_length(n);
   endtask

   function automatic logic [rps_pkg::FRAC_W-1:0] pick_fraction();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 10) return '0;
      if (k < 20) return FRAC_MAX;
      if (k < 28) return FRAC_MAX - rps_pkg::FRAC_W'($urandom_range(0, 255));
      return rps_pkg::FRAC_W'($urandom);
   endfunction

   function automatic logic [rps_pkg::LEN_W-1:0] pick_length();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 35) return rps_pkg::LEN_W'(1);
      if (k < 55) return rps_pkg::LEN_W'($urandom_range(2, 4));
      if (k < 80) return rps_pkg::LEN_W'($urandom_range(5, 40));
      if (k < 88) return rps_pkg::LEN_W'($urandom_range(41, rps_pkg::MAX_ELEMENTS));
      if (k < 92) return '0;
      if (k < 96) return '1;
      return rps_pkg::LEN_W'($urandom_range(0, 2047));
   endfunction

   task automatic random_mode(input int unsigned src_pct, input int unsigned sink_pct,
                              input int unsigned requests);
      int unsigned left;
      int unsigned burst;
      drain();
      src_idle_pct = src_pct;
      sink_idle_pct = sink_pct;
      left = requests;
      while (left > 0) begin
         burst = $urandom_range(10, 60);
         if (burst > left) burst = left;
         drain();
         write_length(pick_length());
         repeat (burst) send_fraction(pick_fraction());
         left -= burst;
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_random_fraction <= '0;
      src_idle_pct = 24;
      sink_idle_pct = 65;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset length: identity picks, far partner, midpoint, near-extremes
      send_fraction('0);
      send_fraction(FRAC_MAX);
      send_fraction(rps_pkg::FRAC_W'(1) << (rps_pkg::FRAC_W - 1));
      send_fraction(rps_pkg::FRAC_W'(1));
      send_fraction(FRAC_MAX - 1);
      drain();
      // zero length behaves as one
      write_length('0);
      send_fraction(FRAC_MAX);
      send_fraction('0);
      drain();
      // oversize length clamps to the maximum
      write_length('1);
      send_fraction(FRAC_MAX);
      send_fraction(rps_pkg::FRAC_W'($urandom));
      drain();
      write_length(rps_pkg::LEN_W'(1));
      send_fraction(FRAC_MAX);
      send_fraction('0);
      drain();
      write_length(rps_pkg::LEN_W'(3));
      send_fraction(FRAC_MAX);
      send_fraction('0);
      send_fraction(FRAC_MAX);
      send_fraction(FRAC_MAX);
      send_fraction('0);
      drain();
      // grow length mid-permutation: continues from current position
      write_length(rps_pkg::LEN_W'(5));
      send_fraction(FRAC_MAX);
      send_fraction(rps_pkg::FRAC_W'($urandom));
      drain();
      // shrink below current position: restarts at position 0
      write_length(rps_pkg::LEN_W'(2));
      send_fraction(FRAC_MAX);
      send_fraction(FRAC_MAX);
      send_fraction('0);

      random_mode(24, 65, 250);
      random_mode(65, 24, 250);
      random_mode(0, 0, 250);

      drain();
      if (tracker.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rps_pkg.sv
hdl/rps_ctrl.sv
hdl/rps_datapath.sv
hdl/random_permutation_shuffle_unit.sv
test/random_permutation_shuffle_unit_tb.sv
